// ===== rtl/core/cmr_pkg.sv =====
// Shared types and constants for the centred moving RMS block.
// No dependencies.
`timescale 1ns / 1ps

package cmr_pkg;

  localparam int unsigned CfgW = 6;                // window_length register width
  localparam logic [CfgW-1:0] PassLimit = 6'd2;    // below this: pass-through

  typedef struct packed {
    logic load;        // take input word
    logic rd;          // read history slot, form square
    logic zero_sq;     // push a zero square (flush)
    logic upd;         // update sum/history/count
    logic flush;       // current push belongs to the flush
    logic div_start;
    logic sqrt_start;
    logic out_load;
    logic clear;       // end of signal: clear history
  } cmd_t;

  typedef struct packed {
    logic pass_mode;   // window below 2
    logic emit;        // count reached half window
    logic seen_zero;
    logic div_done;
    logic sqrt_done;
  } sts_t;

endpackage

// ===== rtl/core/cmr_div.sv =====
// Restoring divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps

module cmr_div #(
  parameter int unsigned DW = 37,
  parameter int unsigned VW = 6
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q, div_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [VW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_q, quo_q[DW-1]};
  assign ge     = rem_sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? VW'(rem_sh - {1'b0, div_q}) : rem_sh[VW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/core/cmr_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle (floor).
// No dependencies.
`timescale 1ns / 1ps

module cmr_sqrt #(
  parameter int unsigned W = 37
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [W-1:0]           radicand_i,
  output logic                   done_o,
  output logic [(W+1)/2-1:0]     root_o
);

  localparam int unsigned RtW = (W + 1) / 2;
  localparam int unsigned RdW = 2 * RtW;
  localparam int unsigned RmW = RtW + 3;
  localparam int unsigned CW  = $clog2(RtW + 1);

  logic [RdW-1:0] rad_q;
  logic [RtW-1:0] root_q;
  logic [RmW-1:0] rem_q, rem_sh, trial;
  logic [CW-1:0]  cnt_q;
  logic           busy_q, done_q, ge;

  assign rem_sh = {rem_q[RmW-3:0], rad_q[RdW-1 -: 2]};
  assign trial  = RmW'({root_q, 2'b01});
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(RtW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= RdW'(radicand_i);
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[RtW-2:0], ge};
      rad_q  <= {rad_q[RdW-3:0], 2'b00};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== rtl/core/cmr_datapath.sv =====
// Datapath: square history memory, running sum, counters, divider, root, output regs.
// Depends on cmr_pkg, cmr_div, cmr_sqrt.
`timescale 1ns / 1ps

module cmr_datapath #(
  parameter int unsigned MAX_WINDOW  = 63,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cmr_pkg::cmd_t                 cmd_i,
  output cmr_pkg::sts_t                 sts_o,
  input  logic                          cfg_we_i,
  input  logic [cmr_pkg::CfgW-1:0]      cfg_data_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          last_sample_i,
  output logic signed [SAMPLE_BITS:0]   rms_value_o,
  output logic                          last_out_o,
  output logic                          last_in_o
);

  localparam int unsigned OutW = SAMPLE_BITS + 1;
  localparam int unsigned SqW  = 2 * SAMPLE_BITS - 1;
  localparam int unsigned SumW = SqW + $clog2(MAX_WINDOW);
  localparam int unsigned NW   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned AW   = $clog2(MAX_WINDOW);
  localparam int unsigned TW   = (NW > cmr_pkg::CfgW) ? NW : cmr_pkg::CfgW;
  localparam int unsigned Cap  = (MAX_WINDOW % 2 == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;
  localparam int unsigned RtW  = (SumW + 1) / 2;

  logic [SqW-1:0]  mem_q [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] vld_q;
  logic [SqW-1:0]  rd_data_q, sq_q, old_sq;
  logic            rd_vld_q;
  logic [SumW-1:0] sum_q, sum_d;
  logic [NW-1:0]   seen_q, n_q, half, wpos_nx;
  logic [AW-1:0]   wpos_q;
  logic [cmr_pkg::CfgW-1:0] wl_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic            last_q, emit_last_q;
  logic [SAMPLE_BITS-1:0] mag;
  logic [2*SAMPLE_BITS-1:0] prod;
  logic [TW-1:0]   t_raw;
  logic [NW-1:0]   taps;
  logic [SumW-1:0] quo;
  logic [RtW-1:0]  root;

  // odd window, capped
  assign t_raw = TW'(cfg_data_i) | TW'(1);
  assign taps  = (t_raw > TW'(Cap)) ? NW'(Cap) : NW'(t_raw);

  assign half    = n_q >> 1;
  assign mag     = sample_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_q) : sample_q;
  assign prod    = mag * mag;
  assign old_sq  = rd_vld_q ? rd_data_q : '0;
  assign sum_d   = sum_q - SumW'(old_sq) + SumW'(sq_q);
  assign wpos_nx = NW'(wpos_q) + NW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q   <= '0;
      n_q    <= NW'(1);
      sum_q  <= '0;
      seen_q <= '0;
      wpos_q <= '0;
      vld_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        wl_q <= cfg_data_i;
        n_q  <= taps;
      end
      if (cfg_we_i || cmd_i.clear) begin
        sum_q  <= '0;
        seen_q <= '0;
        wpos_q <= '0;
        vld_q  <= '0;
      end else if (cmd_i.upd) begin
        sum_q         <= sum_d;
        vld_q[wpos_q] <= 1'b1;
        wpos_q        <= (wpos_nx >= n_q) ? '0 : AW'(wpos_nx);
        if (cmd_i.flush)          seen_q <= seen_q - NW'(1);
        else if (seen_q >= half)  seen_q <= half;
        else                      seen_q <= seen_q + NW'(1);
      end
    end
  end

  // history memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_data_q <= mem_q[wpos_q];
      rd_vld_q  <= vld_q[wpos_q];
      sq_q      <= cmd_i.zero_sq ? '0 : prod[SqW-1:0];
    end
    if (cmd_i.upd) begin
      mem_q[wpos_q] <= sq_q;
      emit_last_q   <= cmd_i.flush && (seen_q == NW'(1));
    end
    if (cmd_i.load) begin
      sample_q <= sample_i;
      last_q   <= last_sample_i;
      if (wl_q < cmr_pkg::PassLimit) begin
        rms_value_o <= OutW'(sample_i);
        last_out_o  <= last_sample_i;
      end
    end
    if (cmd_i.out_load) begin
      rms_value_o <= OutW'(root);
      last_out_o  <= emit_last_q;
    end
  end

  cmr_div #(.DW(SumW), .VW(NW)) u_div (
    .clk_i, .rst_ni,
    .start_i   (cmd_i.div_start),
    .dividend_i(sum_d),
    .divisor_i (n_q),
    .done_o    (sts_o.div_done),
    .quotient_o(quo)
  );

  cmr_sqrt #(.W(SumW)) u_sqrt (
    .clk_i, .rst_ni,
    .start_i   (cmd_i.sqrt_start),
    .radicand_i(quo),
    .done_o    (sts_o.sqrt_done),
    .root_o    (root)
  );

  assign sts_o.pass_mode = wl_q < cmr_pkg::PassLimit;
  assign sts_o.emit      = seen_q >= half;
  assign sts_o.seen_zero = seen_q == '0;
  assign last_in_o       = last_q;

endmodule

// ===== rtl/core/cmr_ctrl.sv =====
// RMS sequencer: read, update, then divide, root, output if due; pass-through: output only.
// Depends on cmr_pkg.
`timescale 1ns / 1ps

module cmr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          cfg_ready_o,
  input  logic          last_in_i,
  input  cmr_pkg::sts_t sts_i,
  output cmr_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_UPD, S_DIV, S_SQRT, S_OUT, S_CLR
  } state_e;

  state_e state_q;
  logic   flush_q, pass_q, out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.flush      = flush_q;
    cmd_o.zero_sq    = flush_q;
    unique case (state_q)
      S_IDLE: cmd_o.load       = in_valid_i;
      S_READ: cmd_o.rd         = 1'b1;
      S_UPD: begin
        cmd_o.upd       = 1'b1;
        cmd_o.div_start = flush_q || sts_i.emit;
      end
      S_DIV:  cmd_o.sqrt_start = sts_i.div_done;
      S_SQRT: cmd_o.out_load   = sts_i.sqrt_done;
      S_CLR:  cmd_o.clear      = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      flush_q     <= 1'b0;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: if (in_valid_i) begin
          pass_q  <= sts_i.pass_mode;
          flush_q <= 1'b0;
          if (sts_i.pass_mode) begin
            out_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end else begin
            state_q <= S_READ;
          end
        end
        S_READ: state_q <= S_UPD;
        S_UPD: begin
          if (flush_q || sts_i.emit) begin
            state_q <= S_DIV;
          end else if (last_in_i) begin
            flush_q <= 1'b1;
            state_q <= S_READ;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_DIV:  if (sts_i.div_done) state_q <= S_SQRT;
        S_SQRT: if (sts_i.sqrt_done) begin
          out_valid_q <= 1'b1;
          state_q     <= S_OUT;
        end
        S_OUT: if (!out_stall_i) begin
          out_valid_q <= 1'b0;
          priority if (pass_q)                      state_q <= S_IDLE;
          else if (flush_q && sts_i.seen_zero)      state_q <= S_CLR;
          else if (flush_q)                         state_q <= S_READ;
          else if (last_in_i) begin
            flush_q <= 1'b1;
            state_q <= S_READ;
          end else                                  state_q <= S_IDLE;
        end
        S_CLR: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign cfg_ready_o = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/centered_moving_rms.sv =====
// Centred moving RMS envelope, top level.
// Depends on cmr_pkg, cmr_ctrl, cmr_datapath.
`timescale 1ns / 1ps

// Usage
// - Input channel (in_valid_i / in_stall_o): one sample word with a last flag.
//   A word is taken when valid is high and stall is low.
// - Output channel (out_valid_o / out_stall_i): RMS words. The receiver holds
//   stall high to keep the current word; the block waits until it is taken.
// - Config channel (cfg_valid_i / cfg_ready_o): window length, taken only
//   while idle. A write also clears the history, as at a new signal.
// - Window below 2: pass-through, one word per sample (accept, then output
//   register); while the receiver stalls, no new sample is taken.
// - Otherwise each sample goes through accept, read history and update sum
//   and, when a result is due, the serial divider, the root unit and the
//   output register; a new sample is taken only once the last is through.
// - The last sample flushes up to N/2 further results, then the history
//   is cleared.
// - Reset: window 0 (pass-through), history and sum zero, nothing pending.

module centered_moving_rms #(
  parameter int unsigned MAX_WINDOW  = 63,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          last_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS:0]   rms_value_o,
  output logic                          last_out_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cmr_pkg::CfgW-1:0]      cfg_data_i
);

  cmr_pkg::cmd_t cmd;
  cmr_pkg::sts_t sts;
  logic          last_in;

  cmr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o,
    .out_valid_o, .out_stall_i,
    .cfg_ready_o,
    .last_in_i(last_in),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  cmr_datapath #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i,
    .sample_i,
    .last_sample_i,
    .rms_value_o,
    .last_out_o,
    .last_in_o    (last_in)
  );

endmodule

// ===== test/testbench.sv =====
// Self-checking bench for centered_moving_rms: directed table, then random signals.
// Depends on cmr_pkg and the centered_moving_rms RTL; predicts results internally.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned NTAPS_MAX = 63;
  localparam int unsigned SETTLE    = 200;      // cycles for a word still in flight
  localparam longint      LIMIT     = 3000000;  // generous cycle ceiling

  typedef struct {
    logic signed [16:0] rms;
    logic               lst;
  } rms_word_t;

  typedef struct {
    int                 win;
    logic signed [15:0] smp;
    bit                 lst;
    bit                 typed;   // expectation written in the row
    logic signed [16:0] rms;
  } row_t;

  logic clk = 1'b0, rst_n = 1'b0;
  logic in_valid = 1'b0, out_stall = 1'b0, cfg_valid = 1'b0, last_smp = 1'b0;
  logic signed [15:0] smp = '0;
  logic [cmr_pkg::CfgW-1:0] cfg_data = '0;
  wire in_stall, out_valid, last_out, cfg_ready;
  wire signed [16:0] rms_value;

  centered_moving_rms u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .sample_i(smp), .last_sample_i(last_smp),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .rms_value_o(rms_value), .last_out_o(last_out),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint unsigned sq_hist [NTAPS_MAX];
  longint unsigned sq_sum;
  int unsigned     pending_cnt, wr_slot, win_len;
  rms_word_t       rms_due[$];
  int              errors = 0;
  bit              calm = 1'b0;      // no idling on either side
  bit              hold_req = 1'b0;  // ask receiver for a long hold-off
  longint          cycles = 0;

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r = 0, t;
    for (int b = 17; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic void clear_history();
    foreach (sq_hist[i]) sq_hist[i] = 0;
    sq_sum = 0;
    pending_cnt = 0;
    wr_slot = 0;
  endfunction

  function automatic int unsigned tap_count();
    int unsigned n = win_len;
    if (n % 2 == 0) n++;
    if (n > NTAPS_MAX) n = NTAPS_MAX;
    return n;
  endfunction

  function automatic void push_square(longint unsigned sq, int unsigned n);
    if (wr_slot >= n) wr_slot = 0;
    sq_sum = sq_sum - sq_hist[wr_slot] + sq;
    sq_hist[wr_slot] = sq;
    wr_slot = (wr_slot + 1 >= n) ? 0 : wr_slot + 1;
  endfunction

  function automatic void queue_rms(int unsigned n, bit lst);
    rms_word_t w;
    w.rms = 17'(floor_sqrt(sq_sum / n));
    w.lst = lst;
    rms_due.push_back(w);
  endfunction

  // expected RMS words for one accepted sample
  function automatic void predict_rms(logic signed [15:0] s, bit lst);
    int unsigned n, half;
    longint unsigned mag;
    rms_word_t w;
    if (win_len < 2) begin
      w.rms = 17'(s);
      w.lst = lst;
      rms_due.push_back(w);
      return;
    end
    n = tap_count();
    half = n / 2;
    mag = (s < 0) ? longint'(-longint'(s)) : longint'(s);
    push_square(mag * mag, n);
    if (pending_cnt >= half) begin
      pending_cnt = half;
      queue_rms(n, lst && half == 0);
    end else begin
      pending_cnt++;
    end
    if (lst) begin
      while (pending_cnt > 0) begin
        push_square(0, n);
        pending_cnt--;
        queue_rms(n, pending_cnt == 0);
      end
      clear_history();
    end
  endfunction

  // called in the step of an acceptance (or while idle); one NBA per step
  task automatic send_word(logic signed [15:0] s, bit lst, bit typed,
                           logic signed [16:0] rms);
    rms_word_t w;
    if (!calm && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 25);
    end
    in_valid <= 1'b1;
    smp      <= s;
    last_smp <= lst;
    do @(posedge clk); while (in_stall);
    if (typed) begin
      w.rms = rms;
      w.lst = lst;
      rms_due.push_back(w);
    end else begin
      predict_rms(s, lst);
    end
  endtask

  // register write only with the block idle and every word drained
  task automatic write_window(int w);
    in_valid <= 1'b0;
    while (rms_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cmr_pkg::CfgW'(w);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    win_len = w;
    clear_history();
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(5))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'(int'($urandom_range(15)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: random stall, a calm stretch, and one long hold-off on request
  int hold_left = 0;
  always @(posedge clk) begin
    rms_word_t w;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t timeout with %0d words outstanding", $time, rms_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (rms_due.size() == 0) begin
        errors++;
        $display("%0t unexpected word: rms %0d last %0b", $time, rms_value, last_out);
      end else begin
        w = rms_due.pop_front();
        if (rms_value !== w.rms || last_out !== w.lst) begin
          errors++;
          $display("%0t mismatch: expected rms %0d last %0b, got rms %0d last %0b",
                   $time, w.rms, w.lst, rms_value, last_out);
        end
      end
    end
    if (hold_req && hold_left == 0) begin
      hold_req  = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && $urandom_range(99) < 25;
    end
  end

  row_t steer[$] = '{
    // pass-through, result is the sample itself
    '{0, 16'sh7fff, 0, 1, 17'sd32767},
    '{0, 16'sh8000, 0, 1, -17'sd32768},
    '{0, 16'sh0000, 1, 1, 17'sd0},
    '{0, 16'shffff, 1, 1, -17'sd1},
    '{1, 16'sh3039, 1, 1, 17'sd12345},
    '{1, 16'sh8000, 1, 1, -17'sd32768},
    // dead trace: zeros in, zeros out
    '{3, 16'sh0000, 0, 0, 0},
    '{3, 16'sh0000, 0, 0, 0},
    '{3, 16'sh0000, 1, 0, 0},
    // full-scale negative: steady state reaches 32768
    '{3, 16'sh8000, 0, 0, 0},
    '{3, 16'sh8000, 0, 0, 0},
    '{3, 16'sh8000, 0, 0, 0},
    '{3, 16'sh8000, 1, 0, 0},
    // one-sample signal, shorter than the window
    '{2, 16'sh7fff, 1, 0, 0},
    '{4, 16'sh0064, 0, 0, 0},
    '{4, 16'shff38, 1, 0, 0},
    '{63, 16'sh7fff, 0, 0, 0},
    '{63, 16'sh8000, 1, 0, 0}
  };

  int phase_win[] = '{62, 2, 0, 63, 5, 1, 9, 63, 17};

  initial begin
    int cur_win = -1;
    int len;
    rst_n = 1'b0;
    win_len = 0;
    clear_history();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (steer[i]) begin
      if (steer[i].win != cur_win) begin
        write_window(steer[i].win);
        cur_win = steer[i].win;
      end
      send_word(steer[i].smp, steer[i].lst, steer[i].typed, steer[i].rms);
    end

    foreach (phase_win[p]) begin
      write_window(phase_win[p]);
      calm = (p == 1);
      if (phase_win[p] == 0) hold_req = 1'b1;  // pass-through fills the block fastest
      for (int k = 0; k < 24; k += len) begin
        len = $urandom_range(40, 1);
        for (int j = 0; j < len; j++)
          send_word(rand_sample(), (j == len - 1) && $urandom_range(9) != 0, 0, 0);
      end
    end
    calm = 1'b0;
    // close any open signal so every owed word is flushed
    send_word(rand_sample(), 1, 0, 0);
    in_valid <= 1'b0;

    while (rms_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/cmr_pkg.sv
rtl/core/cmr_div.sv
rtl/core/cmr_sqrt.sv
rtl/core/cmr_datapath.sv
rtl/core/cmr_ctrl.sv
rtl/core/centered_moving_rms.sv
test/testbench.sv
